// ----- rtl/lobm_pkg.sv -----
// Shared types and constants for the limit order book matcher.
// Used by every file in rtl but lobm_ram; depends on nothing.
package lobm_pkg;

    localparam int PRICE_LEVELS = 256;
    localparam int MAX_ORDERS   = 1024;
    localparam int PRICE_W      = 8;
    localparam int ID_W         = 10;
    localparam int QTY_W        = 32;
    localparam int CNT_W        = 11;
    localparam int LVL_W        = PRICE_W + 1;
    localparam int LVL_COUNT    = 2 * PRICE_LEVELS;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;

    typedef enum logic [1:0] {
        OP_MATCH  = 2'd0,
        OP_MODIFY = 2'd1,
        OP_VOLUME = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    // One decoded transaction waiting in the queue.
    typedef struct packed {
        op_t               op;
        logic              side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]  qty;
        logic [ID_W-1:0]   id;
    } item_t;

    // One entry of the order table.
    typedef struct packed {
        logic               live;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } ord_rec_t;

    // One entry of the level table.
    typedef struct packed {
        logic             nonempty;
        logic [ID_W-1:0]  head;
        logic [ID_W-1:0]  tail;
        logic [QTY_W-1:0] vol;
    } lvl_rec_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_VQ_RD, S_VQ_CHK, S_ORD_RD, S_ORD_CHK, S_LVL_RD,
        S_LVL_CHK, S_UNLINK, S_UL_HEAD, S_UL_WALK, S_UL_WCHK, S_UL_FIX,
        S_LVL_WB, S_WALK_START, S_TL_RD, S_TL_CHK, S_TL_LOOP, S_TL_ORD,
        S_TL_NEXT, S_TL_WB, S_REST_RD, S_REST_CHK, S_DONE
    } state_t;

endpackage

// ----- rtl/limit_order_book_matcher_top.sv -----
// Top level of the limit order book matcher: front queue plus back engine.
// Depends on lobm_pkg, lobm_front, lobm_back and lobm_ram.
//
// Input channel (in_valid / in_stall) carries one transaction per request:
// match, modify, volume query or lookup. Output channel (out_valid /
// out_stall) returns exactly one result transaction per request, in order.
// A two-entry queue separates input acceptance from execution, and the
// result sits in an output register, so new requests are taken while a
// result waits for the receiver.
// A modify to zero quantity and a match on a live id unlink that order,
// walking its level queue when it is not at the head; a match then visits
// price levels in turn and trades against each. The engine runs one
// request at a time; every step is bound by the registered read ports of
// the order, level and link RAMs.
// After reset the engine clears the order and level tables, one entry per
// cycle; in_stall stays high during that pass.
// While out_stall is high the output register holds its result and the engine
// waits with the next one; the queue keeps taking requests until it is full.
module limit_order_book_matcher_top
    import lobm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic               side,
    input  logic [PRICE_W-1:0] price,
    input  logic [QTY_W-1:0]   quantity,
    input  logic [ID_W-1:0]    ord_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CNT_W-1:0]   match_count,
    output logic               found,
    output logic               found_side,
    output logic [PRICE_W-1:0] found_price,
    output logic [QTY_W-1:0]   found_quantity,
    output logic [QTY_W-1:0]   level_total
);

    item_t q_item;
    logic  q_valid;
    logic  q_pop;
    logic  clearing;

    lobm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .side     (side),
        .price    (price),
        .quantity (quantity),
        .ord_id   (ord_id),
        .clearing (clearing),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop)
    );

    lobm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_item         (q_item),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_count    (match_count),
        .found          (found),
        .found_side     (found_side),
        .found_price    (found_price),
        .found_quantity (found_quantity),
        .level_total    (level_total)
    );

endmodule

// ----- rtl/lobm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lobm_front.sv -----
// Front end: accepts input transactions, decodes them and queues them.
// Depends on lobm_pkg.
module lobm_front
    import lobm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic               side,
    input  logic [PRICE_W-1:0] price,
    input  logic [QTY_W-1:0]   quantity,
    input  logic [ID_W-1:0]    ord_id,
    input  logic               clearing,
    output item_t              q_item,
    output logic               q_valid,
    input  logic               q_pop
);

    item_t             q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              push;
    logic              pop;
    item_t             new_item;

    // Decode the incoming transaction into a queue entry.
    always_comb
    begin
        new_item.op    = op_t'(op);
        new_item.side  = side;
        new_item.price = price;
        new_item.qty   = quantity;
        new_item.id    = ord_id;
    end

    assign in_stall = (fill_reg == (QPTR_W+1)'(QDEPTH)) || clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- rtl/lobm_back.sv -----
// Back end: sequencer that executes queued transactions on the order,
// level and link tables and holds the result register. Depends on
// lobm_pkg and lobm_ram.
module lobm_back
    import lobm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              q_item,
    input  logic               q_valid,
    output logic               q_pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CNT_W-1:0]   match_count,
    output logic               found,
    output logic               found_side,
    output logic [PRICE_W-1:0] found_price,
    output logic [QTY_W-1:0]   found_quantity,
    output logic [QTY_W-1:0]   level_total
);

    state_t             state_reg, state_next;
    logic [ID_W-1:0]    clr_cnt_reg, clr_cnt_next;
    item_t              cur_reg, cur_next;
    logic [QTY_W-1:0]   qty_reg, qty_next;
    logic [QTY_W-1:0]   oldq_reg, oldq_next;
    logic [LVL_W-1:0]   lv_reg, lv_next;
    lvl_rec_t           lvl_reg, lvl_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PRICE_W-1:0] p_reg, p_next;
    logic [ID_W-1:0]    prev_reg, prev_next;
    logic [CNT_W-1:0]   steps_reg, steps_next;
    logic               res_found_reg, res_found_next;
    logic               res_side_reg, res_side_next;
    logic [PRICE_W-1:0] res_price_reg, res_price_next;
    logic [QTY_W-1:0]   res_qty_reg, res_qty_next;
    logic [QTY_W-1:0]   res_total_reg, res_total_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;
    logic               out_found_reg, out_found_next;
    logic               out_side_reg, out_side_next;
    logic [PRICE_W-1:0] out_price_reg, out_price_next;
    logic [QTY_W-1:0]   out_qty_reg, out_qty_next;
    logic [QTY_W-1:0]   out_total_reg, out_total_next;

    logic                          ord_we;
    logic [ID_W-1:0]               ord_waddr, ord_raddr;
    ord_rec_t                      ord_wdata, ord_rd;
    logic [$bits(ord_rec_t)-1:0]   ord_rdata;
    logic                          lvl_we;
    logic [LVL_W-1:0]              lvl_waddr, lvl_raddr;
    lvl_rec_t                      lvl_wdata, lvl_rd;
    logic [$bits(lvl_rec_t)-1:0]   lvl_rdata;
    logic                          nxt_we;
    logic [ID_W-1:0]               nxt_waddr, nxt_raddr, nxt_wdata, nxt_rd;

    logic [QTY_W-1:0] tr_amt;
    logic [QTY_W-1:0] tr_rem;
    logic             out_free;

    assign ord_rd   = ord_rec_t'(ord_rdata);
    assign lvl_rd   = lvl_rec_t'(lvl_rdata);
    assign out_free = !out_valid_reg || !out_stall;

    // Trade size against the resting order at the head of a level.
    assign tr_amt = (qty_reg < ord_rd.qty) ? qty_reg : ord_rd.qty;
    assign tr_rem = ord_rd.qty - tr_amt;

    lobm_ram #(.WIDTH($bits(ord_rec_t)), .DEPTH(MAX_ORDERS)) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    lobm_ram #(.WIDTH($bits(lvl_rec_t)), .DEPTH(LVL_COUNT)) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (lvl_raddr),
        .rdata (lvl_rdata)
    );

    lobm_ram #(.WIDTH(ID_W), .DEPTH(MAX_ORDERS)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rd)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ID_W'(MAX_ORDERS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_item.op == OP_VOLUME) ? S_VQ_RD : S_ORD_RD;
                end
            end
            S_VQ_RD:   state_next = S_VQ_CHK;
            S_VQ_CHK:  state_next = S_DONE;
            S_ORD_RD:  state_next = S_ORD_CHK;
            S_ORD_CHK:
            begin
                case (cur_reg.op)
                    OP_MODIFY: state_next = ord_rd.live ? S_LVL_RD : S_DONE;
                    OP_MATCH:  state_next = ord_rd.live ? S_LVL_RD : S_WALK_START;
                    default:   state_next = S_DONE;
                endcase
            end
            S_LVL_RD:  state_next = S_LVL_CHK;
            S_LVL_CHK:
            begin
                if (cur_reg.op == OP_MODIFY && cur_reg.qty != '0)
                begin
                    state_next = S_LVL_WB;
                end
                else
                begin
                    state_next = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                if (!lvl_reg.nonempty)
                begin
                    state_next = S_LVL_WB;
                end
                else if (lvl_reg.head == cur_reg.id)
                begin
                    state_next = (lvl_reg.tail == cur_reg.id) ? S_LVL_WB : S_UL_HEAD;
                end
                else
                begin
                    state_next = S_UL_WALK;
                end
            end
            S_UL_HEAD: state_next = S_LVL_WB;
            S_UL_WALK:
            begin
                state_next = (prev_reg == lvl_reg.tail) ? S_LVL_WB : S_UL_WCHK;
            end
            S_UL_WCHK:
            begin
                if (nxt_rd == cur_reg.id)
                begin
                    state_next = S_UL_FIX;
                end
                else if (steps_reg == CNT_W'(MAX_ORDERS))
                begin
                    state_next = S_LVL_WB;
                end
                else
                begin
                    state_next = S_UL_WALK;
                end
            end
            S_UL_FIX:  state_next = S_LVL_WB;
            S_LVL_WB:
            begin
                state_next = (cur_reg.op == OP_MATCH) ? S_WALK_START : S_DONE;
            end
            S_WALK_START:
            begin
                state_next = (qty_reg == '0) ? S_DONE : S_TL_RD;
            end
            S_TL_RD:   state_next = S_TL_CHK;
            S_TL_CHK:  state_next = S_TL_LOOP;
            S_TL_LOOP:
            begin
                if (qty_reg == '0 || !lvl_reg.nonempty)
                begin
                    state_next = S_TL_WB;
                end
                else
                begin
                    state_next = S_TL_ORD;
                end
            end
            S_TL_ORD:
            begin
                if (tr_rem != '0 || lvl_reg.tail == lvl_reg.head)
                begin
                    state_next = S_TL_WB;
                end
                else
                begin
                    state_next = S_TL_NEXT;
                end
            end
            S_TL_NEXT: state_next = S_TL_LOOP;
            S_TL_WB:
            begin
                if (qty_reg == '0 || p_reg == cur_reg.price)
                begin
                    state_next = S_REST_RD;
                end
                else
                begin
                    state_next = S_TL_RD;
                end
            end
            S_REST_RD:
            begin
                state_next = (qty_reg == '0) ? S_DONE : S_REST_CHK;
            end
            S_REST_CHK: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_CLEAR;
        endcase
    end

    // Datapath, table accesses and result register.
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        cur_next       = cur_reg;
        qty_next       = qty_reg;
        oldq_next      = oldq_reg;
        lv_next        = lv_reg;
        lvl_next       = lvl_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        res_found_next = res_found_reg;
        res_side_next  = res_side_reg;
        res_price_next = res_price_reg;
        res_qty_next   = res_qty_reg;
        res_total_next = res_total_reg;
        out_count_next = out_count_reg;
        out_found_next = out_found_reg;
        out_side_next  = out_side_reg;
        out_price_next = out_price_reg;
        out_qty_next   = out_qty_reg;
        out_total_next = out_total_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        clearing       = 1'b0;
        ord_we         = 1'b0;
        ord_waddr      = '0;
        ord_wdata      = '0;
        ord_raddr      = '0;
        lvl_we         = 1'b0;
        lvl_waddr      = '0;
        lvl_wdata      = '0;
        lvl_raddr      = '0;
        nxt_we         = 1'b0;
        nxt_waddr      = '0;
        nxt_wdata      = '0;
        nxt_raddr      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // Zero the order and level tables, one entry per cycle.
                clearing     = 1'b1;
                ord_we       = 1'b1;
                ord_waddr    = clr_cnt_reg;
                lvl_we       = 1'b1;
                lvl_waddr    = clr_cnt_reg[LVL_W-1:0];
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    cur_next       = q_item;
                    qty_next       = q_item.qty;
                    cnt_next       = '0;
                    res_found_next = 1'b0;
                    res_side_next  = 1'b0;
                    res_price_next = '0;
                    res_qty_next   = '0;
                    res_total_next = '0;
                end
            end
            S_VQ_RD:
            begin
                lvl_raddr = {cur_reg.side, cur_reg.price};
            end
            S_VQ_CHK:
            begin
                res_total_next = lvl_rd.vol;
            end
            S_ORD_RD:
            begin
                ord_raddr = cur_reg.id;
            end
            S_ORD_CHK:
            begin
                oldq_next = ord_rd.qty;
                lv_next   = {ord_rd.side, ord_rd.price};
                if (ord_rd.live && cur_reg.op != OP_MATCH)
                begin
                    res_found_next = 1'b1;
                end
                if (ord_rd.live && cur_reg.op == OP_LOOKUP)
                begin
                    res_side_next  = ord_rd.side;
                    res_price_next = ord_rd.price;
                    res_qty_next   = ord_rd.qty;
                end
            end
            S_LVL_RD:
            begin
                lvl_raddr = lv_reg;
            end
            S_LVL_CHK:
            begin
                // Adjust the level volume and rewrite the order entry.
                lvl_next        = lvl_rd;
                steps_next      = '0;
                ord_we          = 1'b1;
                ord_waddr       = cur_reg.id;
                ord_wdata.side  = lv_reg[LVL_W-1];
                ord_wdata.price = lv_reg[PRICE_W-1:0];
                if (cur_reg.op == OP_MODIFY)
                begin
                    lvl_next.vol   = lvl_rd.vol + cur_reg.qty - oldq_reg;
                    ord_wdata.live = (cur_reg.qty != '0);
                    ord_wdata.qty  = cur_reg.qty;
                end
                else
                begin
                    lvl_next.vol   = lvl_rd.vol - oldq_reg;
                    ord_wdata.live = 1'b0;
                    ord_wdata.qty  = oldq_reg;
                end
            end
            S_UNLINK:
            begin
                if (lvl_reg.nonempty && lvl_reg.head == cur_reg.id)
                begin
                    if (lvl_reg.tail == cur_reg.id)
                    begin
                        lvl_next.nonempty = 1'b0;
                    end
                    else
                    begin
                        nxt_raddr = cur_reg.id;
                    end
                end
                else
                begin
                    prev_next = lvl_reg.head;
                end
            end
            S_UL_HEAD:
            begin
                lvl_next.head = nxt_rd;
            end
            S_UL_WALK:
            begin
                nxt_raddr = prev_reg;
            end
            S_UL_WCHK:
            begin
                // Step along the queue looking for the predecessor.
                if (nxt_rd == cur_reg.id)
                begin
                    nxt_raddr = cur_reg.id;
                end
                else if (steps_reg != CNT_W'(MAX_ORDERS))
                begin
                    prev_next  = nxt_rd;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_UL_FIX:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = prev_reg;
                nxt_wdata = nxt_rd;
                if (lvl_reg.tail == cur_reg.id)
                begin
                    lvl_next.tail = prev_reg;
                end
            end
            S_LVL_WB:
            begin
                lvl_we    = 1'b1;
                lvl_waddr = lv_reg;
                lvl_wdata = lvl_reg;
            end
            S_WALK_START:
            begin
                // A buy walks sell levels upward, a sell walks buy levels down.
                p_next = cur_reg.side ? {PRICE_W{1'b1}} : '0;
            end
            S_TL_RD:
            begin
                lvl_raddr = {~cur_reg.side, p_reg};
                lv_next   = {~cur_reg.side, p_reg};
            end
            S_TL_CHK:
            begin
                lvl_next = lvl_rd;
            end
            S_TL_LOOP:
            begin
                ord_raddr = lvl_reg.head;
            end
            S_TL_ORD:
            begin
                // One trade against the oldest resting order.
                qty_next        = qty_reg - tr_amt;
                lvl_next.vol    = lvl_reg.vol - tr_amt;
                cnt_next        = cnt_reg + 1'b1;
                ord_we          = 1'b1;
                ord_waddr       = lvl_reg.head;
                ord_wdata.live  = (tr_rem != '0);
                ord_wdata.side  = ord_rd.side;
                ord_wdata.price = ord_rd.price;
                ord_wdata.qty   = tr_rem;
                if (tr_rem == '0)
                begin
                    if (lvl_reg.tail == lvl_reg.head)
                    begin
                        lvl_next.nonempty = 1'b0;
                    end
                    else
                    begin
                        nxt_raddr = lvl_reg.head;
                    end
                end
            end
            S_TL_NEXT:
            begin
                lvl_next.head = nxt_rd;
            end
            S_TL_WB:
            begin
                lvl_we    = 1'b1;
                lvl_waddr = lv_reg;
                lvl_wdata = lvl_reg;
                if (qty_reg != '0 && p_reg != cur_reg.price)
                begin
                    p_next = cur_reg.side ? p_reg - 1'b1 : p_reg + 1'b1;
                end
            end
            S_REST_RD:
            begin
                lvl_raddr = {cur_reg.side, cur_reg.price};
            end
            S_REST_CHK:
            begin
                // Append the remainder to the back of its own level.
                lvl_wdata = lvl_rd;
                if (lvl_rd.nonempty)
                begin
                    nxt_we         = 1'b1;
                    nxt_waddr      = lvl_rd.tail;
                    nxt_wdata      = cur_reg.id;
                    lvl_wdata.tail = cur_reg.id;
                end
                else
                begin
                    lvl_wdata.head     = cur_reg.id;
                    lvl_wdata.tail     = cur_reg.id;
                    lvl_wdata.nonempty = 1'b1;
                end
                lvl_wdata.vol   = lvl_rd.vol + qty_reg;
                lvl_we          = 1'b1;
                lvl_waddr       = {cur_reg.side, cur_reg.price};
                ord_we          = 1'b1;
                ord_waddr       = cur_reg.id;
                ord_wdata.live  = 1'b1;
                ord_wdata.side  = cur_reg.side;
                ord_wdata.price = cur_reg.price;
                ord_wdata.qty   = qty_reg;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = cnt_reg;
                    out_found_next = res_found_reg;
                    out_side_next  = res_side_reg;
                    out_price_next = res_price_reg;
                    out_qty_next   = res_qty_reg;
                    out_total_next = res_total_reg;
                end
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        qty_reg       <= qty_next;
        oldq_reg      <= oldq_next;
        lv_reg        <= lv_next;
        lvl_reg       <= lvl_next;
        cnt_reg       <= cnt_next;
        p_reg         <= p_next;
        prev_reg      <= prev_next;
        steps_reg     <= steps_next;
        res_found_reg <= res_found_next;
        res_side_reg  <= res_side_next;
        res_price_reg <= res_price_next;
        res_qty_reg   <= res_qty_next;
        res_total_reg <= res_total_next;
        out_count_reg <= out_count_next;
        out_found_reg <= out_found_next;
        out_side_reg  <= out_side_next;
        out_price_reg <= out_price_next;
        out_qty_reg   <= out_qty_next;
        out_total_reg <= out_total_next;
    end

    assign out_valid      = out_valid_reg;
    assign match_count    = out_count_reg;
    assign found          = out_found_reg;
    assign found_side     = out_side_reg;
    assign found_price    = out_price_reg;
    assign found_quantity = out_qty_reg;
    assign level_total    = out_total_reg;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for limit_order_book_matcher_top.
// Depends on lobm_pkg and the RTL of the matcher; holds its own book predictor.
`timescale 1ns / 1ps

module tb;
    import lobm_pkg::*;

    typedef struct {
        op_t       op;
        bit        side;
        bit [7:0]  price;
        bit [31:0] qty;
        bit [9:0]  id;
    } book_req_t;

    typedef struct {
        bit [10:0] match_count;
        bit        found;
        bit        found_side;
        bit [7:0]  found_price;
        bit [31:0] found_quantity;
        bit [31:0] level_total;
    } book_resp_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         op = OP_MATCH;
    logic               side = 1'b0;
    logic [PRICE_W-1:0] price = '0;
    logic [QTY_W-1:0]   quantity = '0;
    logic [ID_W-1:0]    ord_id = '0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    logic [CNT_W-1:0]   match_count;
    logic               found;
    logic               found_side;
    logic [PRICE_W-1:0] found_price;
    logic [QTY_W-1:0]   found_quantity;
    logic [QTY_W-1:0]   level_total;

    limit_order_book_matcher_top uut (.*);

    // Predicted book state.
    bit        ord_live [MAX_ORDERS];
    bit        ord_side [MAX_ORDERS];
    bit [7:0]  ord_price [MAX_ORDERS];
    bit [31:0] ord_qty [MAX_ORDERS];
    bit [9:0]  ord_next [MAX_ORDERS];
    bit [9:0]  lvl_head [LVL_COUNT];
    bit [9:0]  lvl_tail [LVL_COUNT];
    bit        lvl_busy [LVL_COUNT];
    bit [31:0] lvl_vol [LVL_COUNT];

    book_req_t  order_feed[$];
    book_resp_t results_due[$];
    int         feed_total = 0;
    bit         feed_ready = 1'b0;
    int         taken_n = 0;
    int         seen_n = 0;
    int         error_n = 0;
    int         feed_gap = 0;
    int         drain_gap = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    wire        calm = (taken_n >= feed_total - 150);

    function automatic int level_of(bit s, bit [7:0] p);
        return s * PRICE_LEVELS + p;
    endfunction

    // Take an order out of its level queue and out of the table.
    function automatic void unlink_order(bit [9:0] id);
        int lv;
        bit [9:0] prev;
        int steps;
        lv = level_of(ord_side[id], ord_price[id]);
        ord_live[id] = 1'b0;
        if (!lvl_busy[lv])
            return;
        if (lvl_head[lv] == id) begin
            if (lvl_tail[lv] == id)
                lvl_busy[lv] = 1'b0;
            else
                lvl_head[lv] = ord_next[id];
            return;
        end
        prev = lvl_head[lv];
        steps = 0;
        while (prev != lvl_tail[lv] && ord_next[prev] != id && steps < MAX_ORDERS) begin
            prev = ord_next[prev];
            steps++;
        end
        if (prev == lvl_tail[lv] || ord_next[prev] != id)
            return;
        ord_next[prev] = ord_next[id];
        if (lvl_tail[lv] == id)
            lvl_tail[lv] = prev;
    endfunction

    // Trade the incoming quantity against one level, oldest order first.
    function automatic int trade_level(int lv, ref bit [31:0] left);
        int n;
        bit [9:0] r;
        bit [31:0] t;
        n = 0;
        while (left > 0 && lvl_busy[lv]) begin
            r = lvl_head[lv];
            t = (left < ord_qty[r]) ? left : ord_qty[r];
            ord_qty[r] -= t;
            left -= t;
            lvl_vol[lv] -= t;
            n++;
            if (ord_qty[r] != 0)
                break;
            ord_live[r] = 1'b0;
            if (lvl_tail[lv] == r)
                lvl_busy[lv] = 1'b0;
            else
                lvl_head[lv] = ord_next[r];
        end
        return n;
    endfunction

    function automatic int cross_book(book_req_t q);
        int n;
        int p;
        int lv;
        bit [31:0] left;
        n = 0;
        left = q.qty;
        if (ord_live[q.id]) begin
            lv = level_of(ord_side[q.id], ord_price[q.id]);
            lvl_vol[lv] -= ord_qty[q.id];
            unlink_order(q.id);
        end
        if (!q.side) begin
            for (p = 0; p <= q.price && left > 0; p++)
                n += trade_level(level_of(1'b1, p[7:0]), left);
        end else begin
            p = PRICE_LEVELS;
            while (p > q.price && left > 0) begin
                p--;
                n += trade_level(level_of(1'b0, p[7:0]), left);
            end
        end
        // Any remainder rests at the back of its own level.
        if (left > 0) begin
            lv = level_of(q.side, q.price);
            if (lvl_busy[lv]) begin
                ord_next[lvl_tail[lv]] = q.id;
                lvl_tail[lv] = q.id;
            end else begin
                lvl_head[lv] = q.id;
                lvl_tail[lv] = q.id;
                lvl_busy[lv] = 1'b1;
            end
            ord_live[q.id] = 1'b1;
            ord_side[q.id] = q.side;
            ord_price[q.id] = q.price;
            ord_qty[q.id] = left;
            lvl_vol[lv] += left;
        end
        return n;
    endfunction

    // Apply one request to the predicted book and return its result.
    function automatic book_resp_t apply_request(book_req_t q);
        book_resp_t r;
        int lv;
        r = '{default: 0};
        case (q.op)
            OP_MATCH: r.match_count = 11'(cross_book(q));
            OP_MODIFY: begin
                if (ord_live[q.id]) begin
                    lv = level_of(ord_side[q.id], ord_price[q.id]);
                    lvl_vol[lv] += q.qty - ord_qty[q.id];
                    ord_qty[q.id] = q.qty;
                    if (q.qty == 0)
                        unlink_order(q.id);
                    r.found = 1'b1;
                end
            end
            OP_VOLUME: r.level_total = lvl_vol[level_of(q.side, q.price)];
            default: begin
                if (ord_live[q.id]) begin
                    r.found = 1'b1;
                    r.found_side = ord_side[q.id];
                    r.found_price = ord_price[q.id];
                    r.found_quantity = ord_qty[q.id];
                end
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        error_n++;
        if (error_n <= 50)
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic void add_req(op_t o, bit s, bit [7:0] p, bit [31:0] qn, bit [9:0] i);
        book_req_t q;
        q.op = o;
        q.side = s;
        q.price = p;
        q.qty = qn;
        q.id = i;
        order_feed = {order_feed, q};
    endfunction

    // Random request: mostly a small pool of ids around a crossing price band.
    function automatic void add_random_req();
        int pick;
        op_t o;
        bit s;
        bit [7:0] p;
        bit [31:0] qn;
        bit [9:0] i;
        pick = $urandom_range(0, 99);
        o = (pick < 45) ? OP_MATCH : (pick < 65) ? OP_MODIFY :
            (pick < 80) ? OP_VOLUME : OP_LOOKUP;
        s = 1'($urandom_range(0, 1));
        i = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, 47)) :
            10'($urandom_range(0, 1023));
        if ($urandom_range(0, 99) < 5)
            p = 8'($urandom_range(0, 255));
        else if (o == OP_MATCH)
            p = s ? 8'($urandom_range(124, 136)) : 8'($urandom_range(118, 130));
        else
            p = 8'($urandom_range(116, 138));
        pick = $urandom_range(0, 99);
        if (pick < 7)
            qn = 0;
        else if (pick < 14)
            qn = $urandom;
        else
            qn = $urandom_range(1, 60);
        add_req(o, s, p, qn, i);
    endfunction

    // Clock.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stimulus list, then reset.
    initial
    begin
        add_req(OP_MATCH, 0, 10, 100, 1);
        add_req(OP_MATCH, 0, 10, 50, 2);
        add_req(OP_VOLUME, 0, 10, 0, 0);
        add_req(OP_LOOKUP, 0, 0, 0, 1);
        add_req(OP_MATCH, 1, 255, 0, 3);
        add_req(OP_MATCH, 1, 5, 120, 4);
        add_req(OP_LOOKUP, 1, 0, 0, 2);
        add_req(OP_MATCH, 0, 10, 7, 2);
        add_req(OP_MODIFY, 0, 0, 9, 500);
        add_req(OP_LOOKUP, 0, 0, 0, 500);
        add_req(OP_MATCH, 1, 255, 32'hFFFF_FFFF, 1023);
        add_req(OP_MODIFY, 1, 255, 0, 1023);
        add_req(OP_VOLUME, 1, 255, 0, 0);
        add_req(OP_MATCH, 0, 0, 32'hFFFF_FFFF, 0);
        add_req(OP_MODIFY, 0, 0, 32'h8000_0000, 0);
        add_req(OP_VOLUME, 0, 0, 0, 0);
        add_req(OP_MATCH, 1, 0, 5, 700);
        add_req(OP_LOOKUP, 0, 0, 0, 0);
        add_req(OP_MATCH, 0, 200, 3, 5);
        add_req(OP_MATCH, 0, 200, 4, 6);
        add_req(OP_MATCH, 0, 200, 5, 7);
        add_req(OP_MODIFY, 0, 0, 0, 6);
        add_req(OP_MATCH, 1, 200, 20, 8);
        add_req(OP_VOLUME, 1, 200, 0, 0);
        add_req(OP_LOOKUP, 0, 0, 0, 8);
        repeat (1625)
            add_random_req();
        feed_total = order_feed.size();
        feed_ready = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: offers queued requests with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        book_resp_t due;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (feed_ready && (!in_valid || !in_stall)) begin
            if (in_valid) begin
                due = apply_request(order_feed.pop_front());
                results_due = {results_due, due};
                taken_n <= taken_n + 1;
            end
            if (feed_gap > 0) begin
                feed_gap <= feed_gap - 1;
                in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                feed_gap <= $urandom_range(0, 5);
                in_valid <= 1'b0;
            end else if (order_feed.size() > 0) begin
                in_valid <= 1'b1;
                op <= order_feed[0].op;
                side <= order_feed[0].side;
                price <= order_feed[0].price;
                quantity <= order_feed[0].qty;
                ord_id <= order_feed[0].id;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the block fills and stalls its input.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && seen_n >= 400) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    // Monitor: checks each result transaction against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        book_resp_t want;
        bit stall_now;
        if (!rst_n) begin
            out_stall <= 1'b1;
        end else begin
            if (out_valid && !out_stall) begin
                seen_n <= seen_n + 1;
                if (results_due.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = results_due.pop_front();
                    if (match_count !== want.match_count)
                        report("match_count", match_count, want.match_count);
                    if (found !== want.found)
                        report("found", found, want.found);
                    if (found_side !== want.found_side)
                        report("found_side", found_side, want.found_side);
                    if (found_price !== want.found_price)
                        report("found_price", found_price, want.found_price);
                    if (found_quantity !== want.found_quantity)
                        report("found_quantity", found_quantity, want.found_quantity);
                    if (level_total !== want.level_total)
                        report("level_total", level_total, want.level_total);
                end
            end
            stall_now = 1'b0;
            if (drain_gap > 0) begin
                drain_gap <= drain_gap - 1;
                stall_now = 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                drain_gap <= $urandom_range(0, 5);
                stall_now = 1'b1;
            end
            out_stall <= stall_now || (hold_left > 0);
        end
    end

    // End of run: everything accepted and answered, then a short drain.
    initial
    begin
        wait (feed_ready && rst_n);
        do
            @(posedge clk);
        while (order_feed.size() > 0 || in_valid || results_due.size() > 0);
        repeat (2000) @(posedge clk);
        if (error_n == 0)
            $display("limit_order_book_matcher_top test passed");
        else
            $display("limit_order_book_matcher_top test failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20_000_000;
        $display("limit_order_book_matcher_top test failed");
        $finish;
    end

endmodule
